FILE: rtl/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg: shared types, constants and microcode for the scalar Kalman filter
// Holds the control word layout, the program table and the saturating helpers
// used by the datapath.
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned ProdW    = 2 * (DataW + 1);
  localparam int unsigned FracW    = 16;
  localparam int unsigned ShiftW   = ProdW - FracW;
  localparam int unsigned UcodeLen = 16;
  localparam int unsigned UpcW     = $clog2(UcodeLen);
  localparam int unsigned DivSteps = DataW;
  localparam int unsigned DivCntW  = $clog2(DivSteps + 1);

  // Q16.16 constants.
  localparam logic [DataW-1:0] MinusOneQ = 32'hFFFF_0000;
  localparam logic [DataW-1:0] S32Max    = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] S32Min    = 32'h8000_0000;
  localparam logic [DataW-1:0] U32Max    = 32'hFFFF_FFFF;

  // Register reset values.
  localparam logic [DataW-1:0] StateGainRst  = 32'd65536;
  localparam logic [DataW-1:0] MeasGainRst   = 32'd65536;
  localparam logic [DataW-1:0] ProcNoiseRst  = 32'd98304;
  localparam logic [DataW-1:0] MeasNoiseRst  = 32'd131072;
  localparam logic [DataW-1:0] InitCovRst    = 32'd131072;

  typedef logic [UpcW-1:0] upc_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STATE_GAIN    = 3'd0,
    REG_MEASURE_GAIN  = 3'd1,
    REG_PROCESS_NOISE = 3'd2,
    REG_MEASURE_NOISE = 3'd3,
    REG_INIT_COV      = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // Multiplier operand sources.
  typedef enum logic [3:0] {
    SRC_A, SRC_H, SRC_X, SRC_P, SRC_T, SRC_U, SRC_PP, SRC_XP, SRC_K, SRC_MONE
  } src_e;

  // Operand extension: signed, unsigned or magnitude of a signed value.
  typedef enum logic [1:0] {
    MD_S, MD_U, MD_M
  } mode_e;

  typedef enum logic [2:0] {
    WB_NONE, WB_SATU, WB_SATS, WB_UADD, WB_SADD, WB_SUBCLAMP, WB_GAIN
  } wb_e;

  typedef enum logic [3:0] {
    DST_NONE, DST_T, DST_U, DST_PP, DST_XP, DST_DEN, DST_K, DST_X, DST_P
  } dst_e;

  typedef enum logic [2:0] {
    ADD_Q, ADD_R, ADD_Z, ADD_XP, ADD_PP
  } add_e;

  typedef struct packed {
    src_e  a_src;
    mode_e a_mode;
    src_e  b_src;
    mode_e b_mode;
    wb_e   wb;
    dst_e  dst;
    add_e  add;
    logic  div_start;
    logic  jmp_busy;
    logic  last;
    upc_t  target;
  } ucode_t;

  // Each step issues a product into the product register and writes back the
  // product issued by the step before it.
  function automatic ucode_t ucode_rom(upc_t addr);
    ucode_t w;
    case (addr)
      upc_t'(0):  w = '{SRC_A,  MD_M, SRC_A,    MD_M, WB_NONE,     DST_NONE, ADD_Q,
                        1'b0, 1'b0, 1'b0, upc_t'(0)};
      upc_t'(1):  w = '{SRC_A,  MD_S, SRC_X,    MD_S, WB_SATU,     DST_T,    ADD_Q,
                        1'b0, 1'b0, 1'b0, upc_t'(0)};
      upc_t'(2):  w = '{SRC_T,  MD_U, SRC_P,    MD_U, WB_SATS,     DST_XP,   ADD_Q,
                        1'b0, 1'b0, 1'b0, upc_t'(0)};
      upc_t'(3):  w = '{SRC_H,  MD_M, SRC_H,    MD_M, WB_UADD,     DST_PP,   ADD_Q,
                        1'b0, 1'b0, 1'b0, upc_t'(0)};
      upc_t'(4):  w = '{SRC_H,  MD_S, SRC_XP,   MD_S, WB_SATU,     DST_T,    ADD_Q,
                        1'b0, 1'b0, 1'b0, upc_t'(0)};
      upc_t'(5):  w = '{SRC_T,  MD_U, SRC_PP,   MD_U, WB_SATS,     DST_U,    ADD_Q,
                        1'b0, 1'b0, 1'b0, upc_t'(0)};
      upc_t'(6):  w = '{SRC_H,  MD_M, SRC_PP,   MD_U, WB_UADD,     DST_DEN,  ADD_R,
                        1'b0, 1'b0, 1'b0, upc_t'(0)};
      upc_t'(7):  w = '{SRC_U,  MD_S, SRC_MONE, MD_S, WB_NONE,     DST_NONE, ADD_Q,
                        1'b1, 1'b0, 1'b0, upc_t'(0)};
      upc_t'(8):  w = '{SRC_A,  MD_S, SRC_A,    MD_S, WB_SADD,     DST_U,    ADD_Z,
                        1'b0, 1'b0, 1'b0, upc_t'(0)};
      upc_t'(9):  w = '{SRC_A,  MD_S, SRC_A,    MD_S, WB_NONE,     DST_NONE, ADD_Q,
                        1'b0, 1'b1, 1'b0, upc_t'(9)};
      upc_t'(10): w = '{SRC_A,  MD_S, SRC_A,    MD_S, WB_GAIN,     DST_K,    ADD_Q,
                        1'b0, 1'b0, 1'b0, upc_t'(0)};
      upc_t'(11): w = '{SRC_K,  MD_S, SRC_U,    MD_S, WB_NONE,     DST_NONE, ADD_Q,
                        1'b0, 1'b0, 1'b0, upc_t'(0)};
      upc_t'(12): w = '{SRC_K,  MD_S, SRC_H,    MD_S, WB_SADD,     DST_X,    ADD_XP,
                        1'b0, 1'b0, 1'b0, upc_t'(0)};
      upc_t'(13): w = '{SRC_A,  MD_S, SRC_A,    MD_S, WB_SATS,     DST_T,    ADD_Q,
                        1'b0, 1'b0, 1'b0, upc_t'(0)};
      upc_t'(14): w = '{SRC_T,  MD_S, SRC_PP,   MD_U, WB_NONE,     DST_NONE, ADD_Q,
                        1'b0, 1'b0, 1'b0, upc_t'(0)};
      upc_t'(15): w = '{SRC_A,  MD_S, SRC_A,    MD_S, WB_SUBCLAMP, DST_P,    ADD_PP,
                        1'b0, 1'b0, 1'b1, upc_t'(0)};
      default:    w = '{SRC_A,  MD_S, SRC_A,    MD_S, WB_NONE,     DST_NONE, ADD_Q,
                        1'b0, 1'b0, 1'b1, upc_t'(0)};
    endcase
    return w;
  endfunction

  // Widens a 32-bit operand to the multiplier's 33-bit signed input.
  function automatic logic signed [DataW:0] ext_operand(logic [DataW-1:0] raw, mode_e m);
    logic signed [DataW:0] sx;
    sx = $signed({raw[DataW-1], raw});
    case (m)
      MD_S:    return sx;
      MD_U:    return $signed({1'b0, raw});
      MD_M:    return raw[DataW-1] ? -sx : sx;
      default: return sx;
    endcase
  endfunction

  // Clamp a shifted product to the unsigned 32-bit range.
  function automatic logic [DataW-1:0] sat_u_shift(logic [ShiftW-1:0] v);
    if (v[ShiftW-1]) begin
      return '0;
    end else if (|v[ShiftW-2:DataW]) begin
      return U32Max;
    end
    return v[DataW-1:0];
  endfunction

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic [DataW-1:0] sat_s_wide(logic [ShiftW:0] v);
    if (v[ShiftW:DataW-1] == {(ShiftW - DataW + 2){v[ShiftW]}}) begin
      return v[DataW-1:0];
    end
    return v[ShiftW] ? S32Min : S32Max;
  endfunction

  // Clamp a wide signed value to the unsigned 32-bit range.
  function automatic logic [DataW-1:0] clamp_u_wide(logic [ShiftW:0] v);
    if (v[ShiftW]) begin
      return '0;
    end else if (|v[ShiftW-1:DataW]) begin
      return U32Max;
    end
    return v[DataW-1:0];
  endfunction

endpackage

FILE: rtl/scalar_kalman_filter.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter: one-dimensional Kalman estimator in Q16.16
// A microcoded sequencer steps one shared multiplier and a radix-2 divider
// through predict, gain, correct and covariance update for each sample.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the input channel (in_valid_i, in_stall_o, sample_i); each
// word yields one estimate word on the output channel (out_valid_o,
// out_stall_i, estimate_o). Configuration words (cfg_valid_i, cfg_ready_o,
// cfg_index_i, cfg_data_i) are always taken; unknown indexes are dropped, and
// writes belong in idle periods between samples.
// From acceptance to a valid estimate, a 16-step program issues the eleven
// products through one 33x33 multiplier, and the gain division waits on a
// restoring divider that retires one quotient bit per cycle (the iteration is
// skipped when the divisor is zero or the quotient saturates). A new sample is
// taken as soon as the sequencer is idle, so one sample's program finishes
// before the next one begins.
// Reset loads the register defaults and arms the filter so that the first
// sample seeds the estimate and reloads the covariance from its register.
// While the receiver stalls, the estimate is held in the output register; the
// next sample is still accepted and computed, and its result waits until the
// output register frees.
module scalar_kalman_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [skf_pkg::DataW-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [skf_pkg::DataW-1:0] estimate_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [skf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [skf_pkg::DataW-1:0]     cfg_data_i
);
  import skf_pkg::*;

  // Configuration registers.
  logic [DataW-1:0] state_gain_q, measure_gain_q, process_noise_q;
  logic [DataW-1:0] measure_noise_q, init_cov_q;

  // Sequencer.
  state_e state_q;
  upc_t   upc_q;
  ucode_t uc;
  logic   first_q;
  logic   run;

  // Datapath registers.
  logic [DataW-1:0] x_q, p_q, z_q, t_q, u_q, pp_q, xp_q, den_q, k_q;
  logic [DataW-1:0] est_q;
  logic             out_valid_q;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [DataW:0]   op_a, op_b;
  logic [DataW-1:0] raw_a, raw_b, addend, wb_val, gain;

  // Divider.
  logic [DataW-1:0]   div_rem_q, div_quo_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic               div_ovf_q, div_zero_q, div_busy;
  logic [DataW:0]     div_trial, div_diff;
  logic               div_ge;

  logic in_accept, out_free, cfg_write;

  assign uc          = ucode_rom(upc_q);
  assign run         = (state_q == ST_RUN);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign estimate_o  = $signed(est_q);
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign div_busy    = (div_cnt_q != '0);

  // Operand selection.
  always_comb begin
    case (uc.a_src)
      SRC_A:    raw_a = state_gain_q;
      SRC_H:    raw_a = measure_gain_q;
      SRC_X:    raw_a = x_q;
      SRC_P:    raw_a = p_q;
      SRC_T:    raw_a = t_q;
      SRC_U:    raw_a = u_q;
      SRC_PP:   raw_a = pp_q;
      SRC_XP:   raw_a = xp_q;
      SRC_K:    raw_a = k_q;
      SRC_MONE: raw_a = MinusOneQ;
      default:  raw_a = '0;
    endcase
    case (uc.b_src)
      SRC_A:    raw_b = state_gain_q;
      SRC_H:    raw_b = measure_gain_q;
      SRC_X:    raw_b = x_q;
      SRC_P:    raw_b = p_q;
      SRC_T:    raw_b = t_q;
      SRC_U:    raw_b = u_q;
      SRC_PP:   raw_b = pp_q;
      SRC_XP:   raw_b = xp_q;
      SRC_K:    raw_b = k_q;
      SRC_MONE: raw_b = MinusOneQ;
      default:  raw_b = '0;
    endcase
    case (uc.add)
      ADD_Q:   addend = process_noise_q;
      ADD_R:   addend = measure_noise_q;
      ADD_Z:   addend = z_q;
      ADD_XP:  addend = xp_q;
      ADD_PP:  addend = pp_q;
      default: addend = '0;
    endcase
  end

  assign op_a   = ext_operand(raw_a, uc.a_mode);
  assign op_b   = ext_operand(raw_b, uc.b_mode);
  assign prod_d = ProdW'(op_a) * ProdW'(op_b);

  // Gain from the divider: zero for a zero divisor, else takes the sign of H and saturates as a signed value.
  always_comb begin
    if (div_zero_q) begin
      gain = '0;
    end else if (measure_gain_q[DataW-1]) begin
      gain = (div_ovf_q || (div_quo_q > S32Min)) ? S32Min : (DataW'(0) - div_quo_q);
    end else begin
      gain = (div_ovf_q || div_quo_q[DataW-1]) ? S32Max : div_quo_q;
    end
  end

  // Writeback of the product issued in the previous step.
  always_comb begin
    logic [ShiftW-1:0] sh;
    logic [DataW:0]    sum_u;
    logic [ShiftW:0]   sum_s, diff_s;
    sh     = prod_q[ProdW-1:FracW];
    sum_u  = {1'b0, sat_u_shift(sh)} + {1'b0, addend};
    sum_s  = {sh[ShiftW-1], sh} + {{(ShiftW - DataW + 1){addend[DataW-1]}}, addend};
    diff_s = {{(ShiftW - DataW + 1){1'b0}}, addend} - {sh[ShiftW-1], sh};
    case (uc.wb)
      WB_SATU:     wb_val = sat_u_shift(sh);
      WB_SATS:     wb_val = sat_s_wide({sh[ShiftW-1], sh});
      WB_UADD:     wb_val = sum_u[DataW] ? U32Max : sum_u[DataW-1:0];
      WB_SADD:     wb_val = sat_s_wide(sum_s);
      WB_SUBCLAMP: wb_val = clamp_u_wide(diff_s);
      WB_GAIN:     wb_val = gain;
      default:     wb_val = '0;
    endcase
  end

  // One restoring step: shift in the next numerator bit, subtract if it fits.
  assign div_trial = {div_rem_q, div_quo_q[DataW-1]};
  assign div_ge    = (div_trial >= {1'b0, den_q});
  assign div_diff  = div_trial - {1'b0, den_q};

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      upc_q           <= '0;
      first_q         <= 1'b1;
      out_valid_q     <= 1'b0;
      div_cnt_q       <= '0;
      state_gain_q    <= StateGainRst;
      measure_gain_q  <= MeasGainRst;
      process_noise_q <= ProcNoiseRst;
      measure_noise_q <= MeasNoiseRst;
      init_cov_q      <= InitCovRst;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_STATE_GAIN:    state_gain_q    <= cfg_data_i;
          REG_MEASURE_GAIN:  measure_gain_q  <= cfg_data_i;
          REG_PROCESS_NOISE: process_noise_q <= cfg_data_i;
          REG_MEASURE_NOISE: measure_noise_q <= cfg_data_i;
          REG_INIT_COV:      init_cov_q      <= cfg_data_i;
          default: ;
        endcase
      end

      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (run && uc.div_start) begin
        // Quotients of 2^32 or more and a zero divisor skip the iteration.
        if ((den_q != '0) && (prod_q[2*DataW-1:DataW] < den_q)) begin
          div_cnt_q <= DivCntW'(DivSteps);
        end
      end else if (div_busy) begin
        div_cnt_q <= div_cnt_q - DivCntW'(1);
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            first_q <= 1'b0;
            upc_q   <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (uc.jmp_busy && div_busy) begin
            upc_q <= uc.target;
          end else if (uc.last) begin
            state_q <= ST_DONE;
          end else begin
            upc_q <= upc_q + upc_t'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;

    if (in_accept) begin
      z_q <= sample_i;
      if (first_q) begin
        x_q <= sample_i;
        p_q <= init_cov_q;
      end
    end

    if (run) begin
      case (uc.dst)
        DST_T:   t_q   <= wb_val;
        DST_U:   u_q   <= wb_val;
        DST_PP:  pp_q  <= wb_val;
        DST_XP:  xp_q  <= wb_val;
        DST_DEN: den_q <= wb_val;
        DST_K:   k_q   <= wb_val;
        DST_X:   x_q   <= wb_val;
        DST_P:   p_q   <= wb_val;
        default: ;
      endcase
    end

    if (run && uc.div_start) begin
      div_rem_q  <= prod_q[2*DataW-1:DataW];
      div_quo_q  <= prod_q[DataW-1:0];
      div_zero_q <= (den_q == '0);
      div_ovf_q  <= (prod_q[2*DataW-1:DataW] >= den_q);
    end else if (div_busy) begin
      div_rem_q <= div_ge ? div_diff[DataW-1:0] : div_trial[DataW-1:0];
      div_quo_q <= {div_quo_q[DataW-2:0], div_ge};
    end

    if ((state_q == ST_DONE) && out_free) begin
      est_q <= x_q;
    end
  end

  // The sequencer state is always a single one-hot code.
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  // The divider only runs while a sample is being processed.
  a_div_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> run)
    else $error("divider busy outside of a run");

  // The wait step holds the program counter until the quotient is ready.
  a_wait_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run && uc.jmp_busy && div_busy) |=> (run && (upc_q == $past(upc_q))))
    else $error("sequencer left the divide wait early");

  // The gain is never taken from a divider that is still iterating.
  a_gain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run && (uc.wb == WB_GAIN)) |-> !div_busy)
    else $error("gain written while the divider is busy");

  // Finishing a sample with a free output register presents the estimate.
  a_done_presents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && out_free) |=> (out_valid_o && (state_q == ST_IDLE)))
    else $error("finished estimate not presented");

endmodule
